// ----- hdl/mbe_pkg.sv -----
// Shared types and constants for the Mandelbrot escape-time block.
// No dependencies; imported by every module under hdl/.
package mbe_pkg;

	localparam int CFG_W     = 32;  // configuration write data width
	localparam int CFG_IDX_W = 3;   // configuration register index width
	localparam int STEP_W    = 31;  // per-pixel step registers
	localparam int THR_W     = 4;   // escape threshold, integer part
	localparam int COUNT_W   = 16;  // iteration count / limit

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_REAL_MIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAG_MIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ITER_LIM  = 3'd5;

	// Reset values: view of [-2.0, ..] x [-1.5, ..] in Q4.28, |z|^2 bound 4, 256 iterations
	localparam logic [CFG_W-1:0]   RST_REAL_MIN  = 32'hE000_0000;
	localparam logic [STEP_W-1:0]  RST_REAL_STEP = 31'h0004_0000;
	localparam logic [CFG_W-1:0]   RST_IMAG_MIN  = 32'hE800_0000;
	localparam logic [STEP_W-1:0]  RST_IMAG_STEP = 31'h0003_0000;
	localparam logic [THR_W-1:0]   RST_THRESHOLD = 4'd4;
	localparam logic [COUNT_W-1:0] RST_ITER_LIM  = 16'd256;

	// Control word of a request travelling along the cell chain
	typedef struct packed {
		logic               valid;
		logic               done;   // finished; count holds the answer
		logic [COUNT_W-1:0] count;
	} mbe_ctl_t;

endpackage

// ----- hdl/mandelbrot_escape_time.sv -----
// Mandelbrot escape-time unit: top level with configuration, coordinate setup and cell ring.
// Depends on mbe_pkg, mbe_coord and mbe_cell.
//
// Each request is one pixel (pixel_column, pixel_row). The block forms
// c = (real_min + column*real_step, imag_min + row*imag_step) in signed
// fixed point (FIXED_WIDTH bits, FRAC_BITS fraction bits, Q4.28 by default,
// saturating), then iterates z = z^2 + c from z = 0 and returns iter_count:
// the number of completed steps when |z|^2 first reaches escape_threshold,
// or iteration_limit - 1 if it never does (a limit of 0 acts as 1).
// One pixel is worked on at a time. The iteration runs in a ring of
// NUM_CELLS identical cells; each cell does one full step in two register
// stages (products, then add/saturate/tests) and hands z to the next cell.
// An accepted request passes the input registers and the coordinate
// registers, enters the first cell, and its result is captured once the
// finished request reaches the end of the chain. A new pixel is taken
// as soon as the previous result sits in the output register, even if that
// result has not been collected yet; a finished request that finds the
// output register full keeps circling the ring until it is free.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// must only change while no pixel is in flight.
module mandelbrot_escape_time
	import mbe_pkg::*;
#(
	parameter int FIXED_WIDTH = 32,
	parameter int FRAC_BITS   = 28,
	parameter int COORD_BITS  = 12,
	parameter int NUM_CELLS   = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	// pixel request channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] pixel_column,
	input  logic [COORD_BITS-1:0] pixel_row,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COUNT_W-1:0]    iter_count
);

	localparam int W = FIXED_WIDTH;

	// ---------------- configuration registers ----------------
	logic [CFG_W-1:0]   real_min_q;
	logic [STEP_W-1:0]  real_step_q;
	logic [CFG_W-1:0]   imag_min_q;
	logic [STEP_W-1:0]  imag_step_q;
	logic [THR_W-1:0]   thr_q;
	logic [COUNT_W-1:0] lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_min_q  <= RST_REAL_MIN;
			real_step_q <= RST_REAL_STEP;
			imag_min_q  <= RST_IMAG_MIN;
			imag_step_q <= RST_IMAG_STEP;
			thr_q       <= RST_THRESHOLD;
			lim_q       <= RST_ITER_LIM;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REAL_MIN:  real_min_q  <= cfg_data;
				REG_REAL_STEP: real_step_q <= cfg_data[STEP_W-1:0];
				REG_IMAG_MIN:  imag_min_q  <= cfg_data;
				REG_IMAG_STEP: imag_step_q <= cfg_data[STEP_W-1:0];
				REG_THRESHOLD: thr_q       <= cfg_data[THR_W-1:0];
				REG_ITER_LIM:  lim_q       <= cfg_data[COUNT_W-1:0];
				default: ;  // unknown index: ignored
			endcase
		end
	end

	// zero limit behaves as one
	logic [COUNT_W-1:0] lim_eff;
	assign lim_eff = (lim_q == '0) ? COUNT_W'(1) : lim_q;

	// ---------------- request control ----------------
	logic                  busy_q;    // pixel accepted, result not yet in output register
	logic                  setup_q;   // coordinates being formed this cycle
	logic                  inject_q;  // start request enters the first cell this cycle
	logic [COORD_BITS-1:0] col_q;
	logic [COORD_BITS-1:0] row_q;
	logic                  out_valid_q;
	logic [COUNT_W-1:0]    iter_count_q;
	logic                  in_accept;
	logic                  capture;

	assign in_ready  = !busy_q;
	assign in_accept = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			col_q <= pixel_column;
			row_q <= pixel_row;
		end
	end

	// ---------------- coordinate of c ----------------
	logic signed [W-1:0] cr;
	logic signed [W-1:0] ci;

	mbe_coord #(
		.FIXED_WIDTH (FIXED_WIDTH),
		.COORD_BITS  (COORD_BITS)
	) u_coord_re (
		.clk   (clk),
		.load  (setup_q),
		.cmin  ($signed(real_min_q)),
		.step  (real_step_q),
		.idx   (col_q),
		.coord (cr)
	);

	mbe_coord #(
		.FIXED_WIDTH (FIXED_WIDTH),
		.COORD_BITS  (COORD_BITS)
	) u_coord_im (
		.clk   (clk),
		.load  (setup_q),
		.cmin  ($signed(imag_min_q)),
		.step  (imag_step_q),
		.idx   (row_q),
		.coord (ci)
	);

	// ---------------- cell ring ----------------
	mbe_ctl_t            ctl_in  [NUM_CELLS];
	mbe_ctl_t            ctl_out [NUM_CELLS];
	logic signed [W-1:0] zr_in   [NUM_CELLS];
	logic signed [W-1:0] zi_in   [NUM_CELLS];
	logic signed [W-1:0] zr_out  [NUM_CELLS];
	logic signed [W-1:0] zi_out  [NUM_CELLS];
	mbe_ctl_t            tail;
	mbe_ctl_t            head_ctl;
	logic signed [W-1:0] head_zr;
	logic signed [W-1:0] head_zi;

	assign tail    = ctl_out[NUM_CELLS-1];
	// result leaves the ring at the end of the chain when the output register can take it
	assign capture = tail.valid && tail.done && (!out_valid_q || out_ready);

	// head of the chain: new request, or wrap-around from the tail
	always_comb begin
		if (inject_q) begin
			head_ctl.valid = 1'b1;
			head_ctl.done  = 1'b0;
			head_ctl.count = '0;
			head_zr        = '0;
			head_zi        = '0;
		end else begin
			head_ctl.valid = tail.valid && !capture;
			head_ctl.done  = tail.done;
			head_ctl.count = tail.count;
			head_zr        = zr_out[NUM_CELLS-1];
			head_zi        = zi_out[NUM_CELLS-1];
		end
	end

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		if (i > 0) begin : g_link
			assign ctl_in[i] = ctl_out[i-1];
			assign zr_in[i]  = zr_out[i-1];
			assign zi_in[i]  = zi_out[i-1];
		end else begin : g_head
			assign ctl_in[i] = head_ctl;
			assign zr_in[i]  = head_zr;
			assign zi_in[i]  = head_zi;
		end

		mbe_cell #(
			.FIXED_WIDTH (FIXED_WIDTH),
			.FRAC_BITS   (FRAC_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl_in  (ctl_in[i]),
			.zr_in   (zr_in[i]),
			.zi_in   (zi_in[i]),
			.cr      (cr),
			.ci      (ci),
			.thr     (thr_q),
			.lim     (lim_eff),
			.ctl_out (ctl_out[i]),
			.zr_out  (zr_out[i]),
			.zi_out  (zi_out[i])
		);
	end

	// ---------------- sequencing and output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			setup_q     <= 1'b0;
			inject_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			setup_q  <= in_accept;
			inject_q <= setup_q;
			if (in_accept) begin
				busy_q <= 1'b1;
			end else if (capture) begin
				busy_q <= 1'b0;
			end
			if (capture) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			iter_count_q <= tail.count;
		end
	end

	assign out_valid  = out_valid_q;
	assign iter_count = iter_count_q;

endmodule

// ----- hdl/mbe_coord.sv -----
// Pixel index to fixed-point coordinate: min + index * step, saturated.
// Depends on mbe_pkg.
module mbe_coord
	import mbe_pkg::*;
#(
	parameter int FIXED_WIDTH = 32,
	parameter int COORD_BITS  = 12
) (
	input  logic                          clk,
	input  logic                          load,
	input  logic signed [CFG_W-1:0]       cmin,
	input  logic        [STEP_W-1:0]      step,
	input  logic        [COORD_BITS-1:0]  idx,
	output logic signed [FIXED_WIDTH-1:0] coord
);

	localparam int W     = FIXED_WIDTH;
	localparam int PROD_W = COORD_BITS + STEP_W;
	localparam int SUM_W = (W > PROD_W + 2) ? W : PROD_W + 2;
	localparam logic signed [SUM_W-1:0] CMAX = $signed({{(SUM_W-W+1){1'b0}}, {(W-1){1'b1}}});
	localparam logic signed [SUM_W-1:0] CMIN = $signed({{(SUM_W-W+1){1'b1}}, {(W-1){1'b0}}});

	logic        [PROD_W-1:0] prod;
	logic signed [SUM_W-1:0]  sum;
	logic signed [W-1:0]      coord_nxt;
	logic signed [W-1:0]      coord_q;

	always_comb begin
		prod = PROD_W'(idx) * PROD_W'(step);
		sum  = SUM_W'(cmin) + $signed(SUM_W'(prod));
		if (sum > CMAX) begin
			coord_nxt = CMAX[W-1:0];
		end else if (sum < CMIN) begin
			coord_nxt = CMIN[W-1:0];
		end else begin
			coord_nxt = sum[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			coord_q <= coord_nxt;
		end
	end

	assign coord = coord_q;

endmodule

// ----- hdl/mbe_cell.sv -----
// One iteration cell: z -> z^2 + c with escape and limit tests, two register stages.
// Depends on mbe_pkg.
module mbe_cell
	import mbe_pkg::*;
#(
	parameter int FIXED_WIDTH = 32,
	parameter int FRAC_BITS   = 28
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mbe_ctl_t                      ctl_in,
	input  logic signed [FIXED_WIDTH-1:0] zr_in,
	input  logic signed [FIXED_WIDTH-1:0] zi_in,
	input  logic signed [FIXED_WIDTH-1:0] cr,
	input  logic signed [FIXED_WIDTH-1:0] ci,
	input  logic        [THR_W-1:0]       thr,
	input  logic        [COUNT_W-1:0]     lim,
	output mbe_ctl_t                      ctl_out,
	output logic signed [FIXED_WIDTH-1:0] zr_out,
	output logic signed [FIXED_WIDTH-1:0] zi_out
);

	localparam int W     = FIXED_WIDTH;
	localparam int F     = FRAC_BITS;
	localparam int CMP_W = (W + 1 > F + THR_W) ? W + 1 : F + THR_W;
	localparam logic [2*W-1:0]   HALF    = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};
	localparam logic [2*W-1:0]   HALF_M1 = {{(W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	// Sign-magnitude product, truncated toward zero, saturated
	function automatic logic signed [W-1:0] fx_mul(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic           neg;
		logic [W-1:0]   ma;
		logic [W-1:0]   mb;
		logic [2*W-1:0] q;
		neg = a[W-1] ^ b[W-1];
		ma  = a[W-1] ? $unsigned(-a) : $unsigned(a);
		mb  = b[W-1] ? $unsigned(-b) : $unsigned(b);
		q   = ((2*W)'(ma) * (2*W)'(mb)) >> F;
		if (!neg) begin
			fx_mul = (q > HALF_M1) ? SMAX : $signed(q[W-1:0]);
		end else begin
			fx_mul = (q >= HALF) ? SMIN : $signed(W'(0) - q[W-1:0]);
		end
	endfunction

	function automatic logic signed [W-1:0] sat_w(input logic signed [W:0] s);
		if (s[W] != s[W-1]) begin
			sat_w = s[W] ? SMIN : SMAX;
		end else begin
			sat_w = s[W-1:0];
		end
	endfunction

	function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		sat_add = sat_w((W+1)'(a) + (W+1)'(b));
	endfunction

	function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		sat_sub = sat_w((W+1)'(a) - (W+1)'(b));
	endfunction

	// stage 1: the three products
	mbe_ctl_t            ctl_s1;
	logic signed [W-1:0] sr_s1;
	logic signed [W-1:0] si_s1;
	logic signed [W-1:0] p_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		sr_s1 <= fx_mul(zr_in, zr_in);
		si_s1 <= fx_mul(zi_in, zi_in);
		p_s1  <= fx_mul(zr_in, zi_in);
	end

	// stage 2: tests and update
	logic [CMP_W-1:0]   mag;
	logic [CMP_W-1:0]   thr_fx;
	logic               escape;
	logic [COUNT_W:0]   cnt_inc;
	logic               limit_hit;
	mbe_ctl_t           ctl_nxt;
	logic signed [W-1:0] zr_nxt;
	logic signed [W-1:0] zi_nxt;

	always_comb begin
		mag       = CMP_W'($unsigned(sr_s1)) + CMP_W'($unsigned(si_s1));
		thr_fx    = CMP_W'({thr, {F{1'b0}}});
		escape    = (mag >= thr_fx);
		cnt_inc   = {1'b0, ctl_s1.count} + 1'b1;
		limit_hit = (cnt_inc == {1'b0, lim});
		zr_nxt    = sat_add(sat_sub(sr_s1, si_s1), cr);
		zi_nxt    = sat_add(sat_add(p_s1, p_s1), ci);
		ctl_nxt   = ctl_s1;
		// finished requests pass through untouched; answer is the pre-increment count
		if (ctl_s1.valid && !ctl_s1.done) begin
			if (escape || limit_hit) begin
				ctl_nxt.done = 1'b1;
			end else begin
				ctl_nxt.count = cnt_inc[COUNT_W-1:0];
			end
		end
	end

	mbe_ctl_t            ctl_s2;
	logic signed [W-1:0] zr_s2;
	logic signed [W-1:0] zi_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_nxt;
		end
	end

	always_ff @(posedge clk) begin
		zr_s2 <= zr_nxt;
		zi_s2 <= zi_nxt;
	end

	assign ctl_out = ctl_s2;
	assign zr_out  = zr_s2;
	assign zi_out  = zi_s2;

endmodule
